// File: hdl/running_average_pixel_blend_defines.svh
// assertion macros shared by the checker
`ifndef RUNNING_AVERAGE_PIXEL_BLEND_DEFINES_SVH
`define RUNNING_AVERAGE_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication
`define RAPB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAPB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rapb_pkg.sv
`timescale 1ns / 1ps

package rapb_pkg;

  // store depth, a power of two
  localparam int PIXELS   = 65536;
  localparam int CHANNELS = 3;
  localparam int IDX_W    = $clog2(PIXELS);

  localparam logic [7:0] WEIGHT_MAX = 8'd255;
  localparam logic [7:0] WEIGHT_ONE = 8'd1;

  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [2:0][7:0] pixel_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic             pixel_we;
    logic             weight_we;
    pixel_t           pixel;
    logic [7:0]       weight;
  } store_req_t;

  function automatic logic ch_active(input logic [1:0] k, input logic three);
    return (k == 2'd0) || (three && (int'(k) < CHANNELS));
  endfunction

endpackage

// File: hdl/rapb_store.sv
`timescale 1ns / 1ps

module rapb_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rapb_pkg::store_req_t req_i,
  output logic                ready_o,
  output rapb_pkg::pixel_t    rd_pixel_o,
  output logic [7:0]          rd_weight_o
);

  rapb_pkg::pixel_t pixel_mem [rapb_pkg::PIXELS];
  logic [7:0]       weight_mem [rapb_pkg::PIXELS];

  rapb_pkg::pixel_t        rd_pixel_q;
  logic [7:0]              rd_weight_q;
  logic                    clr_run_q;
  logic [rapb_pkg::IDX_W-1:0] clr_addr_q;

  // weight clearing pass after reset, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_run_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_run_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == rapb_pkg::IDX_W'(rapb_pkg::PIXELS - 1)) begin
        clr_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_run_q) begin
      weight_mem[clr_addr_q] <= '0;
    end else if (req_i.weight_we) begin
      weight_mem[req_i.addr] <= req_i.weight;
    end
    if (req_i.rd_en) begin
      rd_weight_q <= weight_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pixel_we) begin
      pixel_mem[req_i.addr] <= req_i.pixel;
    end
    if (req_i.rd_en) begin
      rd_pixel_q <= pixel_mem[req_i.addr];
    end
  end

  assign ready_o     = !clr_run_q;
  assign rd_pixel_o  = rd_pixel_q;
  assign rd_weight_o = rd_weight_q;

endmodule

// File: hdl/rapb_div.sv
`timescale 1ns / 1ps

// three restoring divider lanes sharing one divisor, one quotient bit per cycle
module rapb_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [2:0][15:0] num_i,
  input  logic [7:0]       den_i,
  output logic             done_o,
  output rapb_pkg::pixel_t quo_o
);

  logic             run_q;
  logic [2:0]       cnt_q;
  logic             done_q;
  logic [2:0][7:0]  rem_q, rem_d;
  logic [2:0][7:0]  low_q, low_d;
  logic [7:0]       den_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [8:0] t;
      logic       ge;
      t  = {rem_q[c], low_q[c][7]};
      ge = t >= {1'b0, den_q};
      rem_d[c] = ge ? 8'(t - {1'b0, den_q}) : t[7:0];
      // quotient bits shift in where the numerator bits leave
      low_d[c] = {low_q[c][6:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && !go_i && (cnt_q == 3'd0);
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= 3'd7;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 3'd0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      den_q <= den_i;
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= num_i[c][15:8];
        low_q[c] <= num_i[c][7:0];
      end
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

// File: hdl/running_average_pixel_blend.sv
`timescale 1ns / 1ps

// Running-average blend of samples into a pixel store with a weight per pixel.
// After reset the weight memory is cleared one entry per cycle, with busy high;
// configuration writes are taken during that time. A transaction is taken when
// start is high and busy is low, and its result appears on the result ports for
// one cycle with done_o high; it must be taken then, there is no way to hold it.
// A clear, an uncovered blend, a blend on a frozen pixel or the first blend of
// a pixel gives its result from the lookup state through the registered done_o,
// and a new transaction can be taken in the cycle that shows that result. An
// averaging blend goes through the memory read with the multiply-add, one
// divider load, eight steps of the bit-per-cycle divider, the write back and
// the result cycle. One transaction is in flight at a time, so the read of the
// next one always sees the previous write.
module running_average_pixel_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] pixel_index_i,
  input  logic        covered_i,
  input  logic [7:0]  sample_c0_i,
  input  logic [7:0]  sample_c1_i,
  input  logic [7:0]  sample_c2_i,
  output logic        done_o,
  output logic [7:0]  pixel_c0_o,
  output logic [7:0]  pixel_c1_o,
  output logic [7:0]  pixel_c2_o,
  output logic [7:0]  weight_now_o,
  output logic        changed_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE
  } state_e;

  state_e                     state_q;
  logic                       three_q;
  logic                       op_q;
  logic                       cov_q;
  rapb_pkg::pixel_t           smp_q;
  logic [rapb_pkg::IDX_W-1:0] idx_q;
  logic [2:0][15:0]           num_q;
  logic [7:0]                 den_q;
  logic                       go_q;

  logic                       done_q;
  rapb_pkg::pixel_t           res_pixel_q;
  logic [7:0]                 res_weight_q;
  logic                       changed_q;

  rapb_pkg::store_req_t       req;
  logic                       store_ready;
  rapb_pkg::pixel_t           rd_pixel;
  logic [7:0]                 rd_weight;
  logic                       div_done;
  rapb_pkg::pixel_t           quo;

  logic                       accept;
  logic                       finish;
  logic                       to_divide;
  logic                       res_changed;
  rapb_pkg::pixel_t           res_pixel;
  logic [7:0]                 res_weight;
  logic [2:0][15:0]           num_d;
  logic [7:0]                 w1;

  assign busy   = (state_q != ST_IDLE) || !store_ready;
  assign accept = start && !busy;
  assign w1     = rd_weight + 8'd1;

  // numerator sample + w*old + (w+1)/2, below 256*(w+1)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_d[c] = 16'(smp_q[c]) + 16'(rd_weight) * 16'(rd_pixel[c]) + 16'(w1[7:1]);
    end
  end

  always_comb begin
    req          = '0;
    req.rd_en    = accept;
    req.addr     = (state_q == ST_IDLE) ? rapb_pkg::IDX_W'(pixel_index_i) : idx_q;
    finish       = 1'b0;
    to_divide    = 1'b0;
    res_changed  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_LOOKUP: begin
        if (op_q == rapb_pkg::OP_CLEAR) begin
          finish        = 1'b1;
          req.weight_we = 1'b1;
          req.weight    = '0;
        end else if (!cov_q || rd_weight == rapb_pkg::WEIGHT_MAX) begin
          finish = 1'b1;
        end else if (rd_weight == 8'd0) begin
          // first sample is copied in
          finish        = 1'b1;
          res_changed   = 1'b1;
          req.pixel_we  = 1'b1;
          req.weight_we = 1'b1;
          req.weight    = rapb_pkg::WEIGHT_ONE;
          for (int c = 0; c < 3; c++) begin
            req.pixel[c] = rapb_pkg::ch_active(2'(c), three_q) ? smp_q[c] : 8'd0;
          end
        end else begin
          to_divide = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          finish        = 1'b1;
          res_changed   = 1'b1;
          req.pixel_we  = 1'b1;
          req.weight_we = 1'b1;
          req.weight    = den_q;
          for (int c = 0; c < 3; c++) begin
            req.pixel[c] = rapb_pkg::ch_active(2'(c), three_q) ? quo[c] : 8'd0;
          end
        end
      end
      default: begin
      end
    endcase
    res_pixel  = req.pixel_we ? req.pixel : rd_pixel;
    res_weight = req.weight_we ? req.weight : rd_weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_q <= 1'b1;
    end else if (cfg_we_i) begin
      three_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      go_q    <= 1'b0;
    end else begin
      done_q <= finish;
      go_q   <= to_divide;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (to_divide) begin
            state_q <= ST_DIVIDE;
          end else if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIVIDE: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      cov_q    <= covered_i;
      idx_q    <= rapb_pkg::IDX_W'(pixel_index_i);
      smp_q[0] <= sample_c0_i;
      smp_q[1] <= sample_c1_i;
      smp_q[2] <= sample_c2_i;
    end
    if (to_divide) begin
      num_q <= num_d;
      den_q <= w1;
    end
    if (finish) begin
      res_pixel_q  <= res_pixel;
      res_weight_q <= res_weight;
      changed_q    <= res_changed;
    end
  end

  rapb_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (store_ready),
    .rd_pixel_o  (rd_pixel),
    .rd_weight_o (rd_weight)
  );

  rapb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign done_o       = done_q;
  assign pixel_c0_o   = res_pixel_q[0];
  assign pixel_c1_o   = res_pixel_q[1];
  assign pixel_c2_o   = res_pixel_q[2];
  assign weight_now_o = res_weight_q;
  assign changed_o    = changed_q;

endmodule

// File: hdl/rapb_checker.sv
`timescale 1ns / 1ps
`include "running_average_pixel_blend_defines.svh"

module rapb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       operation_i,
  input logic       done_o,
  input logic [7:0] weight_now_o,
  input logic       changed_o
);

  logic accept;
  assign accept = start && !busy;

  `RAPB_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !done_o, "no busy after accept")
  `RAPB_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy), "result while idle")
  `RAPB_ASSERT_IMPL(a_changed_weight, clk_i, rst_ni, done_o && changed_o, weight_now_o != 8'd0, "written pixel with zero weight")
  `RAPB_ASSERT_NEXT(a_clear_result, clk_i, rst_ni, accept && operation_i, ##1 (done_o && weight_now_o == 8'd0 && !changed_o), "clear result missing")

endmodule

bind running_average_pixel_blend rapb_checker u_rapb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .operation_i  (operation_i),
  .done_o       (done_o),
  .weight_now_o (weight_now_o),
  .changed_o    (changed_o)
);

// File: tb/sv/pixel_blend_checker.sv
`timescale 1ns / 1ps

module pixel_blend_checker
  import rapb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        operation_i,
  input  logic [15:0] pixel_index_i,
  input  logic        covered_i,
  input  logic [7:0]  sample_c0_i,
  input  logic [7:0]  sample_c1_i,
  input  logic [7:0]  sample_c2_i,
  input  logic        done_i,
  input  logic [7:0]  pixel_c0_i,
  input  logic [7:0]  pixel_c1_i,
  input  logic [7:0]  pixel_c2_i,
  input  logic [7:0]  weight_now_i,
  input  logic        changed_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          averaged_o,
  output int          frozen_hits_o
);

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] weight;
    logic       changed;
  } blend_result_t;

  logic [7:0]    shade_mem [PIXELS][3];
  logic [7:0]    weight_mem [PIXELS];
  logic          three_mode;
  blend_result_t pending_pixels [$];

  function automatic bit lane_on(input int k);
    return (k == 0) || (three_mode && (k < CHANNELS));
  endfunction

  // updates the shadow store and returns the pixel as it stands after the transaction
  function automatic blend_result_t blend_pixel(input logic op, input logic [15:0] pix,
                                                input logic cov, input logic [7:0] s0,
                                                input logic [7:0] s1, input logic [7:0] s2);
    blend_result_t r;
    logic [7:0]    smp [3];
    int unsigned   slot;
    int            w;
    int            w1;
    int            acc;
    smp[0] = s0;
    smp[1] = s1;
    smp[2] = s2;
    slot = pix % PIXELS;
    w = weight_mem[slot];
    r.changed = 1'b0;
    if (op == OP_CLEAR) begin
      weight_mem[slot] = '0;
    end else if (cov) begin
      if (w == 0) begin
        for (int k = 0; k < 3; k++) shade_mem[slot][k] = lane_on(k) ? smp[k] : 8'd0;
        weight_mem[slot] = WEIGHT_ONE;
        r.changed = 1'b1;
      end else if (w < WEIGHT_MAX) begin
        w1 = w + 1;
        for (int k = 0; k < 3; k++) begin
          if (lane_on(k)) begin
            acc = int'(smp[k]) + w * int'(shade_mem[slot][k]) + w1 / 2;
            shade_mem[slot][k] = 8'(acc / w1);
          end else begin
            shade_mem[slot][k] = 8'd0;
          end
        end
        weight_mem[slot] = 8'(w1);
        r.changed = 1'b1;
        averaged_o++;
      end else begin
        frozen_hits_o++;
      end
    end
    r.c0 = shade_mem[slot][0];
    r.c1 = shade_mem[slot][1];
    r.c2 = shade_mem[slot][2];
    r.weight = weight_mem[slot];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blend_result_t seen;
    blend_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PIXELS; i++) weight_mem[i] = '0;
      three_mode = 1'b1;
      pending_pixels.delete();
      mismatches_o = 0;
      outstanding_o = 0;
      averaged_o = 0;
      frozen_hits_o = 0;
    end else begin
      if (done_i) begin
        seen = {pixel_c0_i, pixel_c1_i, pixel_c2_i, weight_now_i, changed_i};
        if (pending_pixels.size() == 0) begin
          $error("result with no transaction waiting");
          mismatches_o++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_c0", want.c0, seen.c0);
          check_field("pixel_c1", want.c1, seen.c1);
          check_field("pixel_c2", want.c2, seen.c2);
          check_field("weight_now", want.weight, seen.weight);
          check_field("changed", 8'(want.changed), 8'(seen.changed));
        end
      end
      if (start_i && !busy_i) begin
        pending_pixels.insert(pending_pixels.size(),
                              blend_pixel(operation_i, pixel_index_i, covered_i,
                                          sample_c0_i, sample_c1_i, sample_c2_i));
      end
      if (cfg_we_i) three_mode = cfg_wdata_i;
      outstanding_o = pending_pixels.size();
    end
  end

endmodule

// File: tb/sv/running_average_pixel_blend_test.sv
`timescale 1ns / 1ps

module running_average_pixel_blend_test;
  import rapb_pkg::*;

  localparam int RESET_CYCLES = 12;
  // the weight clearing pass after reset is the longest quiet stretch
  localparam int STALL_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 30;
  localparam int RAMP_LEN     = 280;
  localparam int PHASE_ITEMS  = 320;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_BLEND;
  logic [15:0] pixel_index = '0;
  logic        covered = 1'b0;
  logic [7:0]  sample_c0 = '0;
  logic [7:0]  sample_c1 = '0;
  logic [7:0]  sample_c2 = '0;
  logic        done;
  logic [7:0]  pixel_c0;
  logic [7:0]  pixel_c1;
  logic [7:0]  pixel_c2;
  logic [7:0]  weight_now;
  logic        changed;

  int mismatches;
  int outstanding;
  int averaged;
  int frozen_hits;

  bit          painted [PIXELS];
  logic [15:0] hot [4];
  logic [15:0] recent [8];
  int          recent_wr = 0;
  bit          gaps_on = 1'b1;
  int          sent = 0;
  int          clears = 0;
  int          uncovered = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  running_average_pixel_blend dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation),
    .pixel_index_i (pixel_index),
    .covered_i     (covered),
    .sample_c0_i   (sample_c0),
    .sample_c1_i   (sample_c1),
    .sample_c2_i   (sample_c2),
    .done_o        (done),
    .pixel_c0_o    (pixel_c0),
    .pixel_c1_o    (pixel_c1),
    .pixel_c2_o    (pixel_c2),
    .weight_now_o  (weight_now),
    .changed_o     (changed)
  );

  pixel_blend_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .operation_i   (operation),
    .pixel_index_i (pixel_index),
    .covered_i     (covered),
    .sample_c0_i   (sample_c0),
    .sample_c1_i   (sample_c1),
    .sample_c2_i   (sample_c2),
    .done_i        (done),
    .pixel_c0_i    (pixel_c0),
    .pixel_c1_i    (pixel_c1),
    .pixel_c2_i    (pixel_c2),
    .weight_now_i  (weight_now),
    .changed_i     (changed),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .averaged_o    (averaged),
    .frozen_hits_o (frozen_hits)
  );

  task automatic send_item(input logic op, input logic [15:0] pix, input logic cov,
                           input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2);
    bit hit;
    // a pixel never written may only be reached by a covered blend
    if (!painted[pix]) begin
      op = OP_BLEND;
      cov = 1'b1;
    end
    while (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    pixel_index <= pix;
    covered <= cov;
    sample_c0 <= s0;
    sample_c1 <= s1;
    sample_c2 <= s2;
    do begin
      @(negedge clk);
      hit = !busy;
      @(posedge clk);
    end while (!hit);
    if (op == OP_BLEND && cov) painted[pix] = 1'b1;
    sent++;
    if (op == OP_CLEAR) clears++;
    else if (!cov) uncovered++;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_mode(input logic three);
    cfg_we <= 1'b1;
    cfg_wdata <= three;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_mixed();
    int          pick;
    logic [15:0] pix;
    logic        op;
    logic        cov;
    pick = $urandom_range(99);
    if (pick < 45) pix = hot[$urandom_range(3)];
    else if (pick < 65) pix = recent[$urandom_range(7)];
    else pix = 16'($urandom_range(65535));
    op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_BLEND;
    cov = ($urandom_range(99) < 85);
    send_item(op, pix, cov, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
    recent[recent_wr] = pix;
    recent_wr = (recent_wr + 1) % 8;
  endtask

  // hammer one pixel until its weight saturates, then clear and restart it
  task automatic send_ramp(input logic [15:0] pix);
    for (int n = 0; n < RAMP_LEN; n++) begin
      send_item(OP_BLEND, pix, ($urandom_range(99) < 97), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    send_item(OP_CLEAR, pix, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, pix, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    hot = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
    for (int i = 0; i < 8; i++) recent[i] = hot[i % 4];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(1'b1);

    // directed: extremes, copy-in, averaging, uncovered, clear
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'h00, 8'h00, 8'h00);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, 16'hFFFF, 1'b1, 8'hFF, 8'h00, 8'hFF);
    send_item(OP_BLEND, 16'hFFFF, 1'b1, 8'h00, 8'hFF, 8'h00);
    send_item(OP_BLEND, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, 16'h0000, 1'b0, 8'hFF, 8'h55, 8'hAA);
    send_item(OP_CLEAR, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'h12, 8'h34, 8'h56);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'hFE, 8'h01, 8'h80);
    send_item(OP_CLEAR, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, 16'hFFFF, 1'b0, 8'h00, 8'h00, 8'h00);
    wait_drain();
    set_mode(1'b0);
    send_item(OP_BLEND, 16'hFFFF, 1'b1, 8'hAA, 8'h55, 8'hAA);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'h00, 8'hFF, 8'hFF);
    send_item(OP_CLEAR, 16'h0000, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_BLEND, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
    send_item(OP_BLEND, 16'h0000, 1'b1, 8'h7F, 8'h80, 8'h81);
    wait_drain();
    set_mode(1'b1);

    // random phases, alternating channel mode between them
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin
        gaps_on = 1'b0;
        send_ramp(16'h3C3C);
        gaps_on = 1'b1;
      end
      if (ph == 3) send_ramp(16'hC3C3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_mixed();
        if (ph == 1 && n == 150) wait_drain();
      end
      wait_drain();
      if (ph < 3) set_mode(ph[0]);
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d transactions: %0d clears, %0d uncovered blends, %0d averaging blends",
             sent, clears, uncovered, averaged);
    $display("%0d covered blends hit a saturated pixel; single and three channel modes both run",
             frozen_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/rapb_pkg.sv
hdl/rapb_store.sv
hdl/rapb_div.sv
hdl/running_average_pixel_blend.sv
hdl/rapb_checker.sv
tb/sv/pixel_blend_checker.sv
tb/sv/running_average_pixel_blend_test.sv
